// ===== rtl/prime_neighbor_search_core_defines.svh =====
// assertion macros shared by the prime neighbor search rtl
// no dependencies; included by the modules that carry assertions
`ifndef PRIME_NEIGHBOR_SEARCH_CORE_DEFINES_SVH
`define PRIME_NEIGHBOR_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define PNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pns assertion failed");

// next-cycle implication, off during reset
`define PNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pns assertion failed");

// condition that must hold on every edge out of reset
`define PNS_ASSERT_ALW(lbl, clk, rst_n, cond) \
	`PNS_ASSERT_IMP(lbl, clk, rst_n, 1'b1, cond)

`endif

// ===== rtl/pns_pkg.sv =====
// shared constants and controller/datapath interface types
// for the prime neighbor search core; no dependencies
`timescale 1ns / 1ps

package pns_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int LOW_LIMIT       = 10;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SMALL    = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic       load;
		logic       set_down;
		logic       set_up;
		logic       dec_cand;
		logic       inc_cand;
		logic       div_init;
		logic       div_next;
		logic       mod_start;
		logic       mod_step;
		logic       rec_down;
		logic       finish;
		logic [1:0] fin_status;
	} cmd_t;

	typedef struct packed {
		logic under_limit;
		logic value_max;
		logic cand_max;
		logic sq_gt;
		logic mod_last;
		logic rem_zero;
	} stat_t;

endpackage

// ===== rtl/prime_neighbor_search_core.sv =====
// top level of the prime neighbor search core
// depends on pns_pkg, pns_ctrl and pns_datapath
`timescale 1ns / 1ps
//
// Usage:
//   A request is taken at a rising edge with start high and busy low;
//   start_value is sampled at that edge. busy stays high while the search
//   runs. The result (next_prime, prev_prime, status) is shown for one
//   cycle with result_valid high and holds its value until the next one.
//   The receiver cannot stall; result_valid rises as busy falls, so a new
//   request may be issued in the same cycle the result is shown.
// Search:
//   Each candidate c is tested with trial divisors d running from 2 up to
//   the first factor or past sqrt(c); each trial runs one bit-serial
//   remainder pass over the W = VALUE_WIDTH bits of c. A start_value of
//   ten or less keeps busy high for one cycle and shows its result in the
//   next cycle with status 1.
// Reset:
//   arst_n clears the controller to idle with no result pending.
//
module prime_neighbor_search_core #(
	parameter int VALUE_WIDTH = pns_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] start_value,
	output logic                   result_valid,
	output logic [VALUE_WIDTH-1:0] next_prime,
	output logic [VALUE_WIDTH-1:0] prev_prime,
	output logic [1:0]             status
);

	pns_pkg::cmd_t  cmd;
	pns_pkg::stat_t stat;

	pns_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.result_valid (result_valid),
		.stat         (stat),
		.cmd          (cmd)
	);

	pns_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_value (start_value),
		.cmd         (cmd),
		.stat        (stat),
		.next_prime  (next_prime),
		.prev_prime  (prev_prime),
		.status      (status)
	);

endmodule

// ===== rtl/pns_datapath.sv =====
// datapath: candidate, trial divisor with running square, bit-serial
// remainder unit and result registers; depends on pns_pkg and the defines header
`timescale 1ns / 1ps
`include "prime_neighbor_search_core_defines.svh"

module pns_datapath #(
	parameter int VALUE_WIDTH = pns_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] start_value,
	input  pns_pkg::cmd_t          cmd,
	output pns_pkg::stat_t         stat,
	output logic [VALUE_WIDTH-1:0] next_prime,
	output logic [VALUE_WIDTH-1:0] prev_prime,
	output logic [1:0]             status
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);
	localparam int SW = VALUE_WIDTH + 2;
	localparam logic [VALUE_WIDTH-1:0] LOW_LIM = VALUE_WIDTH'(pns_pkg::LOW_LIMIT);

	logic [VALUE_WIDTH-1:0] value_q;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [SW-1:0]          sq_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] shf_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] down_q;
	logic [VALUE_WIDTH-1:0] next_q;
	logic [VALUE_WIDTH-1:0] prev_q;
	logic [1:0]             status_q;

	logic [VALUE_WIDTH:0]   part;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	// one restoring step of cand mod div
	assign part = {rem_q, shf_q[VALUE_WIDTH-1]};
	assign diff = part - {1'b0, div_q};
	assign fits = (part >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (cmd.load)
			value_q <= start_value;
		if (cmd.set_down)
			cand_q <= value_q - VALUE_WIDTH'(1);
		else if (cmd.set_up)
			cand_q <= value_q + VALUE_WIDTH'(1);
		else if (cmd.dec_cand)
			cand_q <= cand_q - VALUE_WIDTH'(1);
		else if (cmd.inc_cand)
			cand_q <= cand_q + VALUE_WIDTH'(1);
		if (cmd.div_init) begin
			div_q <= VALUE_WIDTH'(2);
			sq_q  <= SW'(4);
		end else if (cmd.div_next) begin
			div_q <= div_q + VALUE_WIDTH'(1);
			sq_q  <= sq_q + SW'({div_q, 1'b1});
		end
		if (cmd.mod_start) begin
			rem_q <= '0;
			shf_q <= cand_q;
		end else if (cmd.mod_step) begin
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : part[VALUE_WIDTH-1:0];
			shf_q <= {shf_q[VALUE_WIDTH-2:0], 1'b0};
		end
		if (cmd.rec_down)
			down_q <= cand_q;
		if (cmd.finish) begin
			status_q <= cmd.fin_status;
			next_q   <= (cmd.fin_status == pns_pkg::ST_OK) ? cand_q : '0;
			prev_q   <= (cmd.fin_status == pns_pkg::ST_SMALL) ? '0 :
				(cmd.rec_down ? cand_q : down_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mod_start) begin
			cnt_q <= CW'(VALUE_WIDTH);
		end else if (cmd.mod_step) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	assign stat.under_limit = (value_q <= LOW_LIM);
	assign stat.value_max   = (value_q == '1);
	assign stat.cand_max    = (cand_q == '1);
	assign stat.sq_gt       = (sq_q > SW'(cand_q));
	assign stat.mod_last    = (cnt_q == CW'(1));
	assign stat.rem_zero    = (rem_q == '0);

	assign next_prime = next_q;
	assign prev_prime = prev_q;
	assign status     = status_q;

	`PNS_ASSERT_IMP(a_step_counted, clk, arst_n, cmd.mod_step, cnt_q != '0)
	`PNS_ASSERT_IMP(a_no_step_on_start, clk, arst_n, cmd.mod_start, !cmd.mod_step)
	`PNS_ASSERT_NXT(a_ok_above_value, clk, arst_n,
		cmd.finish && cmd.fin_status == pns_pkg::ST_OK, next_q > value_q)

endmodule

// ===== rtl/pns_ctrl.sv =====
// controller: sequences the downward then upward candidate search and
// the trial division loop; depends on pns_pkg and the defines header
`timescale 1ns / 1ps
`include "prime_neighbor_search_core_defines.svh"

module pns_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           result_valid,
	input  pns_pkg::stat_t stat,
	output pns_pkg::cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_TINIT = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_MOD   = 3'd4;
	localparam logic [2:0] S_EVAL  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       up_q;
	logic       up_d;
	logic       done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		up_d    = up_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				if (stat.under_limit) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = pns_pkg::ST_SMALL;
					state_d        = S_IDLE;
				end else begin
					cmd.set_down = 1'b1;
					up_d         = 1'b0;
					state_d      = S_TINIT;
				end
			end
			S_TINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				if (stat.sq_gt) begin
					if (!up_q) begin
						cmd.rec_down = 1'b1;
						if (stat.value_max) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = pns_pkg::ST_OVERFLOW;
							state_d        = S_IDLE;
						end else begin
							cmd.set_up = 1'b1;
							up_d       = 1'b1;
							state_d    = S_TINIT;
						end
					end else begin
						cmd.finish     = 1'b1;
						cmd.fin_status = pns_pkg::ST_OK;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.mod_start = 1'b1;
					state_d       = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				if (!stat.rem_zero) begin
					cmd.div_next = 1'b1;
					state_d      = S_CHECK;
				end else if (!up_q) begin
					cmd.dec_cand = 1'b1;
					state_d      = S_TINIT;
				end else if (stat.cand_max) begin
					cmd.finish     = 1'b1;
					cmd.fin_status = pns_pkg::ST_OVERFLOW;
					state_d        = S_IDLE;
				end else begin
					cmd.inc_cand = 1'b1;
					state_d      = S_TINIT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			up_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			up_q    <= up_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = done_q;

	`PNS_ASSERT_IMP(a_done_after_work, clk, arst_n, done_q, $past(state_q) != S_IDLE)
	`PNS_ASSERT_NXT(a_start_taken, clk, arst_n, state_q == S_IDLE && start, state_q == S_SETUP)
	`PNS_ASSERT_NXT(a_mod_exit, clk, arst_n, state_q == S_MOD,
		state_q == S_MOD || state_q == S_EVAL)

endmodule

// ===== tb/prime_neighbor_search_core_tb.sv =====
// self-checking testbench for prime_neighbor_search_core: directed and random requests,
// each result compared with a trial-division predictor of the nearest primes
// depends on pns_pkg and prime_neighbor_search_core
`timescale 1ns / 1ps

module prime_neighbor_search_core_tb;

	localparam int VW = pns_pkg::VALUE_WIDTH_DEF;
	localparam longint CYCLE_LIMIT = 30_000_000;

	typedef struct packed {
		logic [VW-1:0] next_prime;
		logic [VW-1:0] prev_prime;
		logic [1:0]    status;
	} neighbors_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [VW-1:0] start_value;
	logic          result_valid;
	logic [VW-1:0] next_prime;
	logic [VW-1:0] prev_prime;
	logic [1:0]    status;

	neighbors_t pending_neighbors[$];
	neighbors_t expected_neighbors;
	int         mismatch_count = 0;
	longint     cycle_count = 0;

	prime_neighbor_search_core #(
		.VALUE_WIDTH(VW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.start_value(start_value),
		.result_valid(result_valid),
		.next_prime(next_prime),
		.prev_prime(prev_prime),
		.status(status)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic bit is_prime_value(input int unsigned v);
		int unsigned d;
		if (v < 2)
			return 1'b0;
		for (d = 2; d * d <= v; d++) begin
			if (v % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic neighbors_t predict_neighbors(input logic [VW-1:0] v);
		neighbors_t  r;
		int unsigned c;
		int unsigned top;
		bit          found;
		top = (1 << VW) - 1;
		r = '0;
		if (v <= pns_pkg::LOW_LIMIT) begin
			r.status = pns_pkg::ST_SMALL;
		end else begin
			found = 1'b0;
			for (c = v - 1; c >= 2 && !found; c--) begin
				if (is_prime_value(c)) begin
					r.prev_prime = c[VW-1:0];
					found = 1'b1;
				end
			end
			r.status = pns_pkg::ST_OVERFLOW;
			found = 1'b0;
			for (c = v + 1; c <= top && !found; c++) begin
				if (is_prime_value(c)) begin
					r.next_prime = c[VW-1:0];
					r.status = pns_pkg::ST_OK;
					found = 1'b1;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// start stays high from one request to the next inside a burst
	task automatic send_request(input logic [VW-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		start_value <= v;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_neighbors.push_back(predict_neighbors(v));
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			start_value <= VW'($urandom);
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 0;
		else if (r < 8)
			return $urandom_range(1, 20);
		return $urandom_range(50, 3000);
	endfunction

	// mostly small values keep the trial division short
	function automatic logic [VW-1:0] random_start_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return VW'($urandom_range(0, pns_pkg::LOW_LIMIT));
		else if (r < 20)
			return VW'($urandom_range((1 << VW) - 36, (1 << VW) - 1));
		else if (r < 35)
			return VW'($urandom);
		return VW'($urandom_range(pns_pkg::LOW_LIMIT + 1, 2047));
	endfunction

	task automatic test_too_small();
		send_request(VW'(0));
		send_request(VW'(1));
		send_request(VW'(2));
		send_request(VW'(5));
		send_request(VW'(9));
		send_request(VW'(pns_pkg::LOW_LIMIT));
		idle_sender(random_gap());
	endtask

	task automatic test_lower_boundary();
		send_request(VW'(pns_pkg::LOW_LIMIT + 1));
		send_request(VW'(12));
		send_request(VW'(13));
		send_request(VW'(14));
		send_request(VW'(17));
		send_request(VW'(24));
		idle_sender(random_gap());
	endtask

	// the value just below each of these is a prime square
	task automatic test_prime_squares();
		send_request(VW'(26));
		send_request(VW'(50));
		send_request(VW'(122));
		send_request(VW'(170));
		send_request(VW'(290));
		idle_sender(random_gap());
	endtask

	task automatic test_upper_range();
		send_request(16'h8000);
		send_request(16'h5555);
		send_request(16'hAAAA);
		send_request(VW'(65520));
		send_request(VW'(65521));
		send_request(VW'(65534));
		send_request(16'hFFFF);
		idle_sender(random_gap());
	endtask

	task automatic test_widest_gap();
		send_request(VW'(31400));
		idle_sender(random_gap());
	endtask

	task automatic test_drain_pause();
		send_request(random_start_value());
		send_request(random_start_value());
		idle_sender(1);
		while (pending_neighbors.size() != 0)
			@(posedge clk);
		idle_sender($urandom_range(1, 40));
	endtask

	task automatic test_random_bursts(input int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 8);
			repeat (burst) begin
				send_request(random_start_value());
				sent++;
			end
			idle_sender(random_gap());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1) begin
			if (pending_neighbors.size() == 0) begin
				report_mismatch("result with no request outstanding");
			end else begin
				expected_neighbors = pending_neighbors.pop_front();
				if (next_prime !== expected_neighbors.next_prime)
					report_mismatch($sformatf("next_prime got %0d expected %0d",
						next_prime, expected_neighbors.next_prime));
				if (prev_prime !== expected_neighbors.prev_prime)
					report_mismatch($sformatf("prev_prime got %0d expected %0d",
						prev_prime, expected_neighbors.prev_prime));
				if (status !== expected_neighbors.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						status, expected_neighbors.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		start_value = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_too_small();
		test_lower_boundary();
		test_prime_squares();
		test_drain_pause();
		test_upper_range();
		test_widest_gap();
		test_random_bursts(35);
		test_drain_pause();
		test_random_bursts(35);

		idle_sender(1);
		while (pending_neighbors.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_neighbors.size() != 0)
			report_mismatch("requests left without a result");
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== prime_neighbor_search_core.f =====
+incdir+rtl
rtl/pns_pkg.sv
rtl/pns_datapath.sv
rtl/pns_ctrl.sv
rtl/prime_neighbor_search_core.sv
tb/prime_neighbor_search_core_tb.sv
